// ===== design/lfm_pkg.sv =====
// Shared types and constants for the latency fluctuation monitor.
// Item and result payload structs, register map and alarm level codes.
// No dependencies.
package lfm_pkg;

    // Timestamp width of every time field
    localparam int TIME_BITS = 48;
    // Signed transit difference (receiver - sender)
    localparam int DIFF_BITS = TIME_BITS + 1;
    // Magnitude of a difference of two differences
    localparam int MAG_BITS  = TIME_BITS + 1;

    localparam int RATE_BITS  = 16;
    localparam int LIMIT_BITS = 31;
    localparam int FLUCT_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values
    localparam logic [RATE_BITS-1:0]  RATE_RESET    = 16'd100;
    localparam logic [LIMIT_BITS-1:0] CLAMP_RESET   = 31'd300000;
    localparam logic [LIMIT_BITS-1:0] REF_AGE_RESET = 31'd300000;
    localparam logic [LIMIT_BITS-1:0] STALE_RESET   = 31'd3600000;
    localparam logic [LIMIT_BITS-1:0] ERROR_RESET   = 31'd0;
    localparam logic [LIMIT_BITS-1:0] WARNING_RESET = 31'd0;

    // Register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RATE    = 3'd0,
        CFG_CLAMP   = 3'd1,
        CFG_REF_AGE = 3'd2,
        CFG_STALE   = 3'd3,
        CFG_ERROR   = 3'd4,
        CFG_WARNING = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LEVEL_NONE    = 2'd0,
        LEVEL_WARNING = 2'd1,
        LEVEL_ERROR   = 2'd2
    } alarm_level_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] sender_ms;
        logic [TIME_BITS-1:0] receiver_ms;
        logic [TIME_BITS-1:0] wall_ms;
    } item_t;

    typedef struct packed {
        logic signed [FLUCT_BITS-1:0] fluct_prev;
        logic signed [FLUCT_BITS-1:0] fluct_ref;
        logic                         evaluated;
        alarm_level_t                 alarm_level;
        logic                         alarm_source;
    } result_t;

endpackage

// ===== design/latency_fluctuation_monitor_top.sv =====
// Latency fluctuation monitor: three-stage pipeline, top level.
// Depends on lfm_pkg (payload structs, register map, level codes).
// One item per clock unless stalled; each item gives exactly one result.

// Throughput is one item per cycle when the output side is not stalled;
// items pass the stage-one, two and three registers in turn. Stage one
// registers the wall time and transit difference (receiver - sender). Stage two holds
// the monitor state: it makes the rate and staleness decisions, forms the
// raw change against the previous and reference differences, and updates
// the state in the same cycle, so consecutive items chain through this
// stage at one per cycle. Stage three applies the clamp, picks the larger
// fluctuation (ties go to the reference) and grades it. Items skipped by
// the rate limit return an all-zero result and leave the state untouched.
// Configuration must be written only while the pipeline is empty.
module latency_fluctuation_monitor_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // item channel
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  lfm_pkg::item_t                         item,
    // result channel
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output lfm_pkg::result_t                       result,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [lfm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [lfm_pkg::LIMIT_BITS-1:0]         cfg_data
);
    import lfm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [RATE_BITS-1:0]  rate_reg;
    logic [LIMIT_BITS-1:0] clamp_reg;
    logic [LIMIT_BITS-1:0] ref_age_reg;
    logic [LIMIT_BITS-1:0] stale_reg;
    logic [LIMIT_BITS-1:0] error_reg;
    logic [LIMIT_BITS-1:0] warning_reg;

    // ---------------- monitor state ----------------
    logic signed [DIFF_BITS-1:0] last_diff_reg, last_diff_next;
    logic signed [DIFF_BITS-1:0] ref_diff_reg, ref_diff_next;
    logic [TIME_BITS-1:0]        ref_time_reg, ref_time_next;
    // time of the last check; also serves as the rate-limit reference
    logic [TIME_BITS-1:0]        last_check_reg, last_check_next;
    logic                        has_run_reg, has_run_next;

    // ---------------- pipeline registers ----------------
    logic                        in_valid_reg;
    logic signed [DIFF_BITS-1:0] in_diff_reg, in_diff_next;
    logic [TIME_BITS-1:0]        in_wall_reg;

    logic                        mid_valid_reg;
    logic                        mid_eval_reg, mid_eval_next;
    logic                        mid_stale_reg, mid_stale_next;
    logic                        mid_neg_p_reg, mid_neg_p_next;
    logic [MAG_BITS-1:0]         mid_mag_p_reg, mid_mag_p_next;
    logic                        mid_neg_r_reg, mid_neg_r_next;
    logic [MAG_BITS-1:0]         mid_mag_r_reg, mid_mag_r_next;

    logic                        out_valid_reg;
    result_t                     result_reg, result_next;

    // ---------------- flow control ----------------
    logic out_open;
    logic mid_open;
    logic in_xfer;
    logic mid_load;

    assign out_open   = !out_valid_reg || result_ready;
    assign mid_open   = !mid_valid_reg || out_open;
    assign item_ready = !in_valid_reg || mid_open;
    assign in_xfer    = item_valid && item_ready;
    assign mid_load   = in_valid_reg && mid_open;

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // ---------------- configuration write ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= RATE_RESET;
            clamp_reg   <= CLAMP_RESET;
            ref_age_reg <= REF_AGE_RESET;
            stale_reg   <= STALE_RESET;
            error_reg   <= ERROR_RESET;
            warning_reg <= WARNING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RATE:    rate_reg    <= cfg_data[RATE_BITS-1:0];
                CFG_CLAMP:   clamp_reg   <= cfg_data;
                CFG_REF_AGE: ref_age_reg <= cfg_data;
                CFG_STALE:   stale_reg   <= cfg_data;
                CFG_ERROR:   error_reg   <= cfg_data;
                CFG_WARNING: warning_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ---------------- stage 1: transit difference ----------------
    assign in_diff_next = DIFF_BITS'({1'b0, item.receiver_ms})
                        - DIFF_BITS'({1'b0, item.sender_ms});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_diff_reg <= in_diff_next;
            in_wall_reg <= item.wall_ms;
        end
    end

    // ---------------- stage 2: decisions and state update ----------------
    logic                     wall_ge;
    logic [TIME_BITS-1:0]     gap;
    logic                     skip;
    logic [TIME_BITS:0]       ref_expiry;
    logic                     ref_upd;
    logic signed [DIFF_BITS:0] dp_fwd, dp_bwd, dr_fwd, dr_bwd;

    assign wall_ge = in_wall_reg >= last_check_reg;
    assign gap     = in_wall_reg - last_check_reg;
    assign skip    = has_run_reg && wall_ge && (gap < TIME_BITS'(rate_reg));

    // reference expiry computed one bit wider so the sum cannot wrap
    assign ref_expiry = (TIME_BITS+1)'(ref_time_reg) + (TIME_BITS+1)'(ref_age_reg);
    assign ref_upd    = (ref_expiry < {1'b0, in_wall_reg}) || (in_diff_reg < ref_diff_reg);

    // both subtraction orders in parallel; the sign of one picks the magnitude
    assign dp_fwd = {in_diff_reg[DIFF_BITS-1], in_diff_reg}
                  - {last_diff_reg[DIFF_BITS-1], last_diff_reg};
    assign dp_bwd = {last_diff_reg[DIFF_BITS-1], last_diff_reg}
                  - {in_diff_reg[DIFF_BITS-1], in_diff_reg};
    assign dr_fwd = {in_diff_reg[DIFF_BITS-1], in_diff_reg}
                  - {ref_diff_reg[DIFF_BITS-1], ref_diff_reg};
    assign dr_bwd = {ref_diff_reg[DIFF_BITS-1], ref_diff_reg}
                  - {in_diff_reg[DIFF_BITS-1], in_diff_reg};

    always_comb
    begin
        mid_eval_next  = !skip;
        mid_stale_next = wall_ge && (gap >= TIME_BITS'(stale_reg));
        mid_neg_p_next = dp_fwd[DIFF_BITS];
        mid_mag_p_next = dp_fwd[DIFF_BITS] ? dp_bwd[MAG_BITS-1:0] : dp_fwd[MAG_BITS-1:0];
        mid_neg_r_next = dr_fwd[DIFF_BITS];
        mid_mag_r_next = dr_fwd[DIFF_BITS] ? dr_bwd[MAG_BITS-1:0] : dr_fwd[MAG_BITS-1:0];
    end

    always_comb
    begin
        last_diff_next  = last_diff_reg;
        ref_diff_next   = ref_diff_reg;
        ref_time_next   = ref_time_reg;
        last_check_next = last_check_reg;
        has_run_next    = has_run_reg;
        if (mid_load && !skip)
        begin
            has_run_next    = 1'b1;
            last_check_next = in_wall_reg;
            last_diff_next  = in_diff_reg;
            if (ref_upd)
            begin
                ref_diff_next = in_diff_reg;
                ref_time_next = in_wall_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_diff_reg  <= '0;
            ref_diff_reg   <= '0;
            ref_time_reg   <= '0;
            last_check_reg <= '0;
            has_run_reg    <= 1'b0;
            mid_valid_reg  <= 1'b0;
        end
        else
        begin
            last_diff_reg  <= last_diff_next;
            ref_diff_reg   <= ref_diff_next;
            ref_time_reg   <= ref_time_next;
            last_check_reg <= last_check_next;
            has_run_reg    <= has_run_next;
            if (mid_open)
            begin
                mid_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_load)
        begin
            mid_eval_reg  <= mid_eval_next;
            mid_stale_reg <= mid_stale_next;
            mid_neg_p_reg <= mid_neg_p_next;
            mid_mag_p_reg <= mid_mag_p_next;
            mid_neg_r_reg <= mid_neg_r_next;
            mid_mag_r_reg <= mid_mag_r_next;
        end
    end

    // ---------------- stage 3: clamp, pick and grade ----------------
    logic [LIMIT_BITS-1:0] ap, ar, pick;
    logic                  src_ref;
    logic                  zero_p, zero_r;

    assign zero_p  = mid_stale_reg || (mid_mag_p_reg > MAG_BITS'(clamp_reg));
    assign zero_r  = mid_stale_reg || (mid_mag_r_reg > MAG_BITS'(clamp_reg));
    assign ap      = zero_p ? '0 : mid_mag_p_reg[LIMIT_BITS-1:0];
    assign ar      = zero_r ? '0 : mid_mag_r_reg[LIMIT_BITS-1:0];
    assign src_ref = !(ap > ar);
    assign pick    = src_ref ? ar : ap;

    always_comb
    begin
        result_next = '0;
        if (mid_eval_reg)
        begin
            result_next.evaluated    = 1'b1;
            result_next.alarm_source = src_ref;
            result_next.fluct_prev   = mid_neg_p_reg ? -FLUCT_BITS'(ap) : FLUCT_BITS'(ap);
            result_next.fluct_ref    = mid_neg_r_reg ? -FLUCT_BITS'(ar) : FLUCT_BITS'(ar);
            priority if (pick > error_reg)
                result_next.alarm_level = LEVEL_ERROR;
            else if (pick > warning_reg)
                result_next.alarm_level = LEVEL_WARNING;
            else
                result_next.alarm_level = LEVEL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_open && mid_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // ---------------- assertions ----------------
    // rate-skipped items come out all zero
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.evaluated) |->
            (result_reg.fluct_prev == '0 && result_reg.fluct_ref == '0 &&
             result_reg.alarm_level == LEVEL_NONE && !result_reg.alarm_source))
        else $error("skipped item produced nonzero result");

    // any checked item leaves the monitor marked as run at its wall time
    a_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_load && !skip) |=> (has_run_reg && last_check_reg == $past(in_wall_reg)))
        else $error("state not updated after a check");

    // a reference refresh takes the same difference as the last check
    a_ref_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_load && !skip && ref_upd) |=> (ref_diff_reg == last_diff_reg))
        else $error("reference refresh out of step with last difference");

    // a stalled middle stage keeps its item
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && !out_open) |=>
            (mid_valid_reg && $stable(mid_mag_p_reg) && $stable(mid_eval_reg)))
        else $error("middle stage lost an item under stall");

    // a skipped item never touches the state
    a_skip_state: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_load && skip) |=> ($stable(last_diff_reg) && $stable(ref_diff_reg) &&
                                $stable(last_check_reg)))
        else $error("skipped item changed monitor state");

endmodule
